// ===== rtl/core/ghr_pkg.sv =====
package ghr_pkg;

   // field widths fixed by the request and result formats
   localparam int OPC_W      = 2;
   localparam int POS_W      = 13;
   localparam int CH_W       = 5;
   localparam int PIX_W      = 6;
   localparam int HEAT_W     = 16;
   localparam int RAD_W      = 14;
   localparam int COORD_W    = 7;
   localparam int CTR_W      = 12;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 14;
   localparam int D_W        = 28;
   localparam int E_W        = 19;

   localparam int DEF_MAX_WIDTH       = 64;
   localparam int DEF_MAX_HEIGHT      = 64;
   localparam int DEF_CHANNELS        = 32;
   localparam int DEF_EXP_TABLE_DEPTH = 256;

   localparam int QUEUE_DEPTH = 2;

   localparam logic [RAD_W-1:0]   RESET_RADIUS = 14'd2048;
   localparam logic [COORD_W-1:0] RESET_WIDTH  = 7'd64;
   localparam logic [COORD_W-1:0] RESET_HEIGHT = 7'd64;

   localparam longint unsigned SQRT_2TH_Q16 = 64'd198893;
   localparam longint unsigned TH_Q16       = 64'd301806;
   localparam longint unsigned LN2_Q30      = 64'd744261118;
   localparam longint unsigned ONE_Q30      = 64'd1073741824;

   typedef enum logic [OPC_W-1:0] {
      OP_DRAW  = 2'd0,
      OP_READ  = 2'd1,
      OP_CLEAR = 2'd2
   } opcode_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SPREAD_RADIUS = 2'd0,
      CSR_MAP_WIDTH     = 2'd1,
      CSR_MAP_HEIGHT    = 2'd2
   } csr_index_type;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_WALK,
      BK_DRAIN,
      BK_READ,
      BK_CLEAR
   } back_state_type;

   typedef struct packed {
      opcode_type         op;
      logic [CH_W-1:0]    channel;
      logic [COORD_W-1:0] x_lo;
      logic [COORD_W-1:0] x_hi;
      logic [COORD_W-1:0] y_lo;
      logic [COORD_W-1:0] y_hi;
      logic [CTR_W-1:0]   cx;
      logic [CTR_W-1:0]   cy;
      logic               rd_zero;
      logic [PIX_W-1:0]   rd_col;
      logic [PIX_W-1:0]   rd_row;
   } cmd_type;

   // truncating quotient by shift and subtract, for the series terms
   function automatic longint unsigned div_term(input longint unsigned num,
                                                input longint unsigned den);
      longint unsigned rem;
      longint unsigned quo;
      rem = 0;
      quo = 0;
      for (int b = 63; b >= 0; b--) begin
         rem = {rem[62:0], num[b]};
         quo = {quo[62:0], 1'b0};
         if (rem >= den) begin
            rem    = rem - den;
            quo[0] = 1'b1;
         end
      end
      return quo;
   endfunction

   // exp(-t) in Q0.16 from t in Q16, evaluated at elaboration for the table
   function automatic logic [HEAT_W-1:0] exp_neg_q16(input longint unsigned t_q16);
      longint unsigned r;
      longint unsigned mag;
      longint unsigned v;
      longint unsigned q;
      longint          sum;
      int unsigned     k;
      r   = t_q16 << 14;
      k   = 0;
      mag = ONE_Q30;
      sum = longint'(ONE_Q30);
      for (int j = 0; j < 60; j++) begin
         if (r >= LN2_Q30) begin
            r = r - LN2_Q30;
            k++;
         end
      end
      for (int n = 1; n <= 16; n++) begin
         mag = div_term((mag * r) >> 30, 64'(n));
         if ((n & 1) == 1) sum = sum - longint'(mag);
         else sum = sum + longint'(mag);
      end
      if (sum < 0) sum = 0;
      v = longint'(sum) >> k;
      q = (v + 64'd8192) >> 14;
      if (q > 64'd65535) q = 64'd65535;
      return q[HEAT_W-1:0];
   endfunction

endpackage

// ===== rtl/core/ghr_req_if.sv =====
interface ghr_req_if import ghr_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic [OPC_W-1:0]        opcode;
   logic signed [POS_W-1:0] x_pos;
   logic signed [POS_W-1:0] y_pos;
   logic [CH_W-1:0]         channel;
   logic [PIX_W-1:0]        pixel_col;
   logic [PIX_W-1:0]        pixel_row;

   modport source (output valid, opcode, x_pos, y_pos, channel, pixel_col, pixel_row,
                   input ready);
   modport sink (input valid, opcode, x_pos, y_pos, channel, pixel_col, pixel_row,
                 output ready);
endinterface

// ===== rtl/core/ghr_rsp_if.sv =====
interface ghr_rsp_if import ghr_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [HEAT_W-1:0] heat_value;

   modport source (output valid, heat_value, input ready);
   modport sink (input valid, heat_value, output ready);
endinterface

// ===== rtl/core/gaussian_heatmap_render_unit.sv =====
// channel   dir   handshake      payload
// req_bus   in    valid/ready    opcode, x_pos, y_pos, channel, pixel_col, pixel_row
// rsp_bus   out   valid/ready    heat_value (read requests only)
// csr_*     in    csr_wr_en      csr_index, csr_wdata
//
// Draw: the walker issues a pixel a cycle into the pixel pipeline, whose exponent comes
//   from the 19-stage divider.
// Read: the addressed store word is registered and returned; clear: one store word per
//   cycle through the single write port.
// Reset: a clearing pass over all CHANNELS*MAX_HEIGHT*MAX_WIDTH store words (131072 by
//   default) runs first, with requests held off; configuration writes are taken throughout.
// A stalled response holds one result; a further read waits at the queue head, and requests behind it wait too.
module gaussian_heatmap_render_unit import ghr_pkg::*; #(
   parameter int MAX_WIDTH       = DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT      = DEF_MAX_HEIGHT,
   parameter int CHANNELS        = DEF_CHANNELS,
   parameter int EXP_TABLE_DEPTH = DEF_EXP_TABLE_DEPTH
) (
   input  logic                  clock,
   input  logic                  reset,
   ghr_req_if.sink               req_bus,
   ghr_rsp_if.source             rsp_bus,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   logic [RAD_W-1:0]   radius_ff, radius_in;
   logic [COORD_W-1:0] map_width_ff, map_width_in;
   logic [COORD_W-1:0] map_height_ff, map_height_in;

   logic    init_busy, q_full, q_push, q_pop, q_valid;
   cmd_type push_cmd, head_cmd;

   always_comb begin
      radius_in     = radius_ff;
      map_width_in  = map_width_ff;
      map_height_in = map_height_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_SPREAD_RADIUS: radius_in     = csr_wdata[RAD_W-1:0];
            CSR_MAP_WIDTH:     map_width_in  = csr_wdata[COORD_W-1:0];
            CSR_MAP_HEIGHT:    map_height_in = csr_wdata[COORD_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff     <= RESET_RADIUS;
         map_width_ff  <= RESET_WIDTH;
         map_height_ff <= RESET_HEIGHT;
      end else begin
         radius_ff     <= radius_in;
         map_width_ff  <= map_width_in;
         map_height_ff <= map_height_in;
      end
   end

   ghr_front #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT),
      .CHANNELS   (CHANNELS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_bus    (req_bus),
      .radius     (radius_ff),
      .map_width  (map_width_ff),
      .map_height (map_height_ff),
      .init_busy  (init_busy),
      .q_full     (q_full),
      .q_push     (q_push),
      .q_cmd      (push_cmd)
   );

   ghr_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_cmd   (push_cmd),
      .pop        (q_pop),
      .head       (head_cmd),
      .head_valid (q_valid),
      .full       (q_full)
   );

   ghr_back #(
      .MAX_WIDTH       (MAX_WIDTH),
      .MAX_HEIGHT      (MAX_HEIGHT),
      .CHANNELS        (CHANNELS),
      .EXP_TABLE_DEPTH (EXP_TABLE_DEPTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .radius    (radius_ff),
      .q_head    (head_cmd),
      .q_valid   (q_valid),
      .q_pop     (q_pop),
      .init_busy (init_busy),
      .rsp_bus   (rsp_bus)
   );

endmodule

// ===== rtl/core/ghr_front.sv =====
module ghr_front import ghr_pkg::*; #(
   parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
   parameter int CHANNELS   = DEF_CHANNELS
) (
   input  logic               clock,
   input  logic               reset,
   ghr_req_if.sink            req_bus,
   input  logic [RAD_W-1:0]   radius,
   input  logic [COORD_W-1:0] map_width,
   input  logic [COORD_W-1:0] map_height,
   input  logic               init_busy,
   input  logic               q_full,
   output logic               q_push,
   output cmd_type            q_cmd
);

   logic                    hold_ff, hold_in;
   logic [OPC_W-1:0]        op_ff;
   logic signed [POS_W-1:0] x_ff, y_ff;
   logic [CH_W-1:0]         ch_ff;
   logic [PIX_W-1:0]        col_ff, row_ff;
   logic [RAD_W-1:0]        spread_ff, spread_in;

   logic [RAD_W-1:0]   rad;
   logic [COORD_W-1:0] w_use, h_use;
   logic [CTR_W-1:0]   cx, cy;
   logic [COORD_W-1:0] x_lo, y_lo, x_hi, y_hi;
   logic [8:0]         x_end, y_end;
   logic               ch_ok, keep, done, accept;

   assign rad       = (radius == '0) ? RAD_W'(1) : radius;
   assign spread_in = RAD_W'((64'(rad) * SQRT_2TH_Q16) >> 18);

   assign w_use = (32'(map_width) > MAX_WIDTH) ? COORD_W'(MAX_WIDTH) : map_width;
   assign h_use = (32'(map_height) > MAX_HEIGHT) ? COORD_W'(MAX_HEIGHT) : map_height;

   assign cx = x_ff[CTR_W-1:0];
   assign cy = y_ff[CTR_W-1:0];

   always_comb begin
      x_lo  = ({2'b0, cx} < spread_ff) ? '0
            : COORD_W'(({2'b0, cx} - spread_ff) >> 6);
      y_lo  = ({2'b0, cy} < spread_ff) ? '0
            : COORD_W'(({2'b0, cy} - spread_ff) >> 6);
      x_end = 9'(({3'b0, cx} + {1'b0, spread_ff}) >> 6) + 9'd1;
      y_end = 9'(({3'b0, cy} + {1'b0, spread_ff}) >> 6) + 9'd1;
      x_hi  = (x_end > {2'b0, w_use}) ? w_use : x_end[COORD_W-1:0];
      y_hi  = (y_end > {2'b0, h_use}) ? h_use : y_end[COORD_W-1:0];
   end

   assign ch_ok = 32'(ch_ff) < CHANNELS;

   always_comb begin
      q_cmd.op      = OP_DRAW;
      q_cmd.channel = ch_ff;
      q_cmd.x_lo    = x_lo;
      q_cmd.x_hi    = x_hi;
      q_cmd.y_lo    = y_lo;
      q_cmd.y_hi    = y_hi;
      q_cmd.cx      = cx;
      q_cmd.cy      = cy;
      q_cmd.rd_zero = !(ch_ok && 32'(col_ff) < MAX_WIDTH && 32'(row_ff) < MAX_HEIGHT);
      q_cmd.rd_col  = col_ff;
      q_cmd.rd_row  = row_ff;
      keep          = 1'b0;
      case (op_ff)
         OP_DRAW: begin
            keep = !x_ff[POS_W-1] && !y_ff[POS_W-1] && ch_ok && (x_lo < x_hi) && (y_lo < y_hi);
         end
         OP_READ: begin
            q_cmd.op = OP_READ;
            keep     = 1'b1;
         end
         OP_CLEAR: begin
            q_cmd.op = OP_CLEAR;
            keep     = 1'b1;
         end
         default: keep = 1'b0;
      endcase
   end

   assign done          = hold_ff && (!keep || !q_full);
   assign q_push        = hold_ff && keep && !q_full;
   assign req_bus.ready = !init_busy && (!hold_ff || done);
   assign accept        = req_bus.valid && req_bus.ready;
   assign hold_in       = accept ? 1'b1 : (done ? 1'b0 : hold_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_ff <= 1'b0;
      end else begin
         hold_ff <= hold_in;
      end
   end

   always_ff @(posedge clock) begin
      spread_ff <= spread_in;
      if (accept) begin
         op_ff  <= req_bus.opcode;
         x_ff   <= req_bus.x_pos;
         y_ff   <= req_bus.y_pos;
         ch_ff  <= req_bus.channel;
         col_ff <= req_bus.pixel_col;
         row_ff <= req_bus.pixel_row;
      end
   end

endmodule

// ===== rtl/core/ghr_queue.sv =====
module ghr_queue import ghr_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_cmd,
   input  logic    pop,
   output cmd_type head,
   output logic    head_valid,
   output logic    full
);

   localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CW = $clog2(QUEUE_DEPTH + 1);

   cmd_type         slot_mem [QUEUE_DEPTH];
   logic [PW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]   count_ff, count_in;
   logic            do_push, do_pop;

   assign full       = (count_ff == CW'(QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head       = slot_mem[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (do_push) wr_ptr_in = (wr_ptr_ff == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + PW'(1);
      if (do_pop) rd_ptr_in = (rd_ptr_ff == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + PW'(1);
      count_in = count_ff + CW'(do_push) - CW'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) slot_mem[wr_ptr_ff] <= push_cmd;
   end

endmodule

// ===== rtl/core/ghr_back.sv =====
module ghr_back import ghr_pkg::*; #(
   parameter int MAX_WIDTH       = DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT      = DEF_MAX_HEIGHT,
   parameter int CHANNELS        = DEF_CHANNELS,
   parameter int EXP_TABLE_DEPTH = DEF_EXP_TABLE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic [RAD_W-1:0] radius,
   input  cmd_type          q_head,
   input  logic             q_valid,
   output logic             q_pop,
   output logic             init_busy,
   ghr_rsp_if.source        rsp_bus
);

   localparam int Depth = CHANNELS * MAX_HEIGHT * MAX_WIDTH;
   localparam int AW    = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int IW    = (EXP_TABLE_DEPTH > 1) ? $clog2(EXP_TABLE_DEPTH) : 1;
   localparam int NW    = E_W + IW;
   localparam int RS    = NW + E_W;
   localparam int MW    = RS - 17;
   localparam int PWD   = NW + MW;
   localparam longint unsigned Recip = ((64'd1 << RS) + TH_Q16 - 64'd1) / TH_Q16;
   localparam logic [MW-1:0] RecipV  = MW'(Recip);

   back_state_type state_ff, state_in;

   logic               init_ff, init_in;
   logic [AW-1:0]      clr_cnt_ff, clr_cnt_in;
   logic [COORD_W-1:0] x_ff, x_in, y_ff, y_in;
   logic [COORD_W-1:0] x_hi_ff, y_lo_ff, y_hi_ff;
   logic [CTR_W-1:0]   cx_ff, cy_ff;
   logic [CH_W-1:0]    ch_ff;
   logic               rd_zero_ff;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [HEAT_W-1:0]  rsp_data_ff;
   logic [D_W-1:0]     r2_ff;

   logic ld_walk, ld_read, ld_clear, issue, clr_we, rsp_load;
   logic walk_last, clr_last, rsp_busy, pipe_empty;
   logic [RAD_W-1:0] rad;

   // pixel pipeline
   logic                    p0_v_ff, p1_v_ff, p3_v_ff, p4_v_ff, p5_v_ff;
   logic signed [13:0]      dx0_ff, dy0_ff;
   logic [AW-1:0]           addr0_ff, addr1_ff, addr3_ff, addr4_ff, addr5_ff;
   logic signed [D_W-1:0]   sq_x, sq_y;
   logic [D_W-1:0]          d1_ff;
   logic [D_W-1:0]          dv_rem_ff [E_W];
   logic [E_W-1:0]          dv_q_ff [E_W];
   logic                    dv_v_ff [E_W];
   logic [AW-1:0]           dv_addr_ff [E_W];
   logic [NW-1:0]           num3_ff;
   logic [PWD-1:0]          prod4;
   logic [IW:0]             idx_raw;
   logic [IW-1:0]           idx4_ff, idx4_in;
   logic [HEAT_W-1:0]       lut5_ff;
   logic [HEAT_W-1:0]       exp_rom [EXP_TABLE_DEPTH];
   logic [E_W-1:0]          e_val;
   logic [AW-1:0]           issue_addr, head_addr;

   // store
   logic [HEAT_W-1:0] heat_mem [Depth];
   logic [HEAT_W-1:0] mem_q_ff;
   logic [AW-1:0]     mem_ra, mem_wa;
   logic [HEAT_W-1:0] mem_wd;
   logic              mem_we;

   for (genvar i = 0; i < EXP_TABLE_DEPTH; i++) begin : g_rom
      localparam longint unsigned TQ =
         (longint'(i) * TH_Q16) / longint'(EXP_TABLE_DEPTH - 1);
      assign exp_rom[i] = exp_neg_q16(TQ);
   end

   assign rad       = (radius == '0) ? RAD_W'(1) : radius;
   assign init_busy = init_ff;
   assign rsp_busy  = rsp_valid_ff && !rsp_bus.ready;
   assign walk_last = (x_ff == x_hi_ff - COORD_W'(1)) && (y_ff == y_hi_ff - COORD_W'(1));
   assign clr_last  = (clr_cnt_ff == AW'(Depth - 1));

   always_comb begin
      pipe_empty = !(p0_v_ff || p1_v_ff || p3_v_ff || p4_v_ff || p5_v_ff);
      for (int k = 0; k < E_W; k++) begin
         if (dv_v_ff[k]) pipe_empty = 1'b0;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         BK_IDLE: begin
            if (q_valid) begin
               case (q_head.op)
                  OP_DRAW:  state_in = BK_WALK;
                  OP_READ:  state_in = rsp_busy ? BK_IDLE : BK_READ;
                  OP_CLEAR: state_in = BK_CLEAR;
                  default:  state_in = BK_IDLE;
               endcase
            end
         end
         BK_WALK:  if (walk_last) state_in = BK_DRAIN;
         BK_DRAIN: if (pipe_empty) state_in = BK_IDLE;
         BK_READ:  state_in = BK_IDLE;
         BK_CLEAR: if (clr_last) state_in = BK_IDLE;
         default:  state_in = BK_IDLE;
      endcase
   end

   // control outputs
   always_comb begin
      q_pop    = 1'b0;
      ld_walk  = 1'b0;
      ld_read  = 1'b0;
      ld_clear = 1'b0;
      issue    = 1'b0;
      clr_we   = 1'b0;
      rsp_load = 1'b0;
      case (state_ff)
         BK_IDLE: begin
            if (q_valid) begin
               case (q_head.op)
                  OP_DRAW: begin
                     q_pop   = 1'b1;
                     ld_walk = 1'b1;
                  end
                  OP_READ: begin
                     q_pop   = !rsp_busy;
                     ld_read = !rsp_busy;
                  end
                  OP_CLEAR: begin
                     q_pop    = 1'b1;
                     ld_clear = 1'b1;
                  end
                  default: q_pop = 1'b1;
               endcase
            end
         end
         BK_WALK:  issue    = 1'b1;
         BK_READ:  rsp_load = 1'b1;
         BK_CLEAR: clr_we   = 1'b1;
         default: begin
         end
      endcase
   end

   always_comb begin
      x_in = x_ff;
      y_in = y_ff;
      if (ld_walk) begin
         x_in = q_head.x_lo;
         y_in = q_head.y_lo;
      end else if (issue) begin
         if (y_ff == y_hi_ff - COORD_W'(1)) begin
            y_in = y_lo_ff;
            x_in = x_ff + COORD_W'(1);
         end else begin
            y_in = y_ff + COORD_W'(1);
         end
      end
      clr_cnt_in = ld_clear ? '0 : (clr_we ? clr_cnt_ff + AW'(1) : clr_cnt_ff);
      init_in    = (clr_we && clr_last) ? 1'b0 : init_ff;
      rsp_valid_in = rsp_load || (rsp_valid_ff && !rsp_bus.ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_CLEAR;
         init_ff      <= 1'b1;
         clr_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         init_ff      <= init_in;
         clr_cnt_ff   <= clr_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff  <= x_in;
      y_ff  <= y_in;
      r2_ff <= D_W'(rad) * D_W'(rad);
      if (ld_walk) begin
         x_hi_ff <= q_head.x_hi;
         y_lo_ff <= q_head.y_lo;
         y_hi_ff <= q_head.y_hi;
         cx_ff   <= q_head.cx;
         cy_ff   <= q_head.cy;
         ch_ff   <= q_head.channel;
      end
      if (ld_read) rd_zero_ff <= q_head.rd_zero;
      if (rsp_load) rsp_data_ff <= rd_zero_ff ? '0 : mem_q_ff;
   end

   assign rsp_bus.valid      = rsp_valid_ff;
   assign rsp_bus.heat_value = rsp_data_ff;

   // addresses: (channel * rows + row) * cols + col
   assign issue_addr = AW'((32'(ch_ff) * MAX_HEIGHT + 32'(y_ff)) * MAX_WIDTH + 32'(x_ff));
   assign head_addr  = AW'((32'(q_head.channel) * MAX_HEIGHT + 32'(q_head.rd_row)) * MAX_WIDTH
                           + 32'(q_head.rd_col));

   always_ff @(posedge clock) begin
      if (reset) begin
         p0_v_ff <= 1'b0;
         p1_v_ff <= 1'b0;
         p3_v_ff <= 1'b0;
         p4_v_ff <= 1'b0;
         p5_v_ff <= 1'b0;
      end else begin
         p0_v_ff <= issue;
         p1_v_ff <= p0_v_ff;
         p3_v_ff <= dv_v_ff[E_W-1] && (e_val <= E_W'(TH_Q16));
         p4_v_ff <= p3_v_ff;
         p5_v_ff <= p4_v_ff;
      end
   end

   assign sq_x  = dx0_ff * dx0_ff;
   assign sq_y  = dy0_ff * dy0_ff;
   assign e_val = dv_q_ff[E_W-1];

   always_ff @(posedge clock) begin
      dx0_ff   <= $signed({1'b0, x_ff, 6'd0}) - $signed({2'b0, cx_ff});
      dy0_ff   <= $signed({1'b0, y_ff, 6'd0}) - $signed({2'b0, cy_ff});
      addr0_ff <= issue_addr;
      d1_ff    <= $unsigned(sq_x) + $unsigned(sq_y);
      addr1_ff <= addr0_ff;
   end

   // restoring divider, one quotient bit per stage; d < r2 keeps e below 2^19
   for (genvar k = 0; k < E_W; k++) begin : g_div
      logic [D_W-1:0] rem_src;
      logic [E_W-1:0] q_src;
      logic           v_src;
      logic [AW-1:0]  a_src;
      logic [D_W:0]   dbl;
      logic           ge;
      if (k == 0) begin : g_first
         assign rem_src = d1_ff;
         assign q_src   = '0;
         assign v_src   = p1_v_ff && (d1_ff < r2_ff);
         assign a_src   = addr1_ff;
      end else begin : g_next
         assign rem_src = dv_rem_ff[k-1];
         assign q_src   = dv_q_ff[k-1];
         assign v_src   = dv_v_ff[k-1];
         assign a_src   = dv_addr_ff[k-1];
      end
      assign dbl = {rem_src, 1'b0};
      assign ge  = dbl >= {1'b0, r2_ff};
      always_ff @(posedge clock) begin
         if (reset) begin
            dv_v_ff[k] <= 1'b0;
         end else begin
            dv_v_ff[k] <= v_src;
         end
      end
      always_ff @(posedge clock) begin
         dv_rem_ff[k]  <= ge ? D_W'(dbl - {1'b0, r2_ff}) : D_W'(dbl);
         dv_q_ff[k]    <= {q_src[E_W-2:0], ge};
         dv_addr_ff[k] <= a_src;
      end
   end

   // table index: round(e * (depth-1) / threshold) by reciprocal multiply
   assign prod4   = PWD'(num3_ff) * PWD'(RecipV);
   assign idx_raw = prod4[RS +: IW+1];
   assign idx4_in = (idx_raw >= (IW+1)'(EXP_TABLE_DEPTH)) ? IW'(EXP_TABLE_DEPTH - 1)
                                                          : idx_raw[IW-1:0];

   always_ff @(posedge clock) begin
      num3_ff  <= NW'(e_val) * NW'(EXP_TABLE_DEPTH - 1) + NW'(TH_Q16 / 2);
      addr3_ff <= dv_addr_ff[E_W-1];
      idx4_ff  <= idx4_in;
      addr4_ff <= addr3_ff;
      lut5_ff  <= exp_rom[idx4_ff];
      addr5_ff <= addr4_ff;
   end

   assign mem_ra = p4_v_ff ? addr4_ff : head_addr;
   assign mem_we = clr_we || (p5_v_ff && (mem_q_ff < lut5_ff));
   assign mem_wa = clr_we ? clr_cnt_ff : addr5_ff;
   assign mem_wd = clr_we ? '0 : lut5_ff;

   always_ff @(posedge clock) begin
      if (mem_we) heat_mem[mem_wa] <= mem_wd;
      mem_q_ff <= heat_mem[mem_ra];
   end

   a_no_merge_in_clear: assert property (@(posedge clock) disable iff (reset)
      (state_ff == BK_CLEAR) |-> !p5_v_ff)
      else $error("pixel merge during store clear");

   a_pop_from_idle: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> (state_ff == BK_IDLE))
      else $error("queue popped outside idle");

   a_read_slot_free: assert property (@(posedge clock) disable iff (reset)
      (state_ff == BK_READ) |-> !rsp_valid_ff)
      else $error("read result would overwrite pending response");

   a_walk_in_window: assert property (@(posedge clock) disable iff (reset)
      (state_ff == BK_WALK) |-> (x_ff < x_hi_ff) && (y_ff < y_hi_ff))
      else $error("walker left draw window");

   a_idle_pipe_empty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == BK_DRAIN) && (state_in == BK_IDLE) |=> !p5_v_ff && !p0_v_ff)
      else $error("pixel pipeline busy after drain");

endmodule

// ===== tb/ghr_heat_monitor.sv =====
module ghr_heat_monitor import ghr_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   ghr_req_if                    req,
   ghr_rsp_if                    rsp,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output int                    errors,
   output int                    pending
);

   localparam int PLANE_W = DEF_MAX_WIDTH;
   localparam int PLANE_H = DEF_MAX_HEIGHT;
   localparam int PLANES  = DEF_CHANNELS;
   localparam int LUT_N   = DEF_EXP_TABLE_DEPTH;

   logic [HEAT_W-1:0]  heat_store [PLANES*PLANE_H*PLANE_W];
   logic [HEAT_W-1:0]  exp_table [LUT_N];
   logic [HEAT_W-1:0]  heat_due [$];
   logic [RAD_W-1:0]   radius;
   logic [COORD_W-1:0] map_w;
   logic [COORD_W-1:0] map_h;

   assign pending = heat_due.size();

   // exp(-t), t in Q16, by range reduction on ln2 and a truncated series in Q30
   function automatic logic [HEAT_W-1:0] decay_q16(longint unsigned t);
      longint unsigned r;
      longint unsigned mag;
      longint unsigned v;
      longint unsigned q;
      longint          sum;
      int              k;
      r   = t << 14;
      k   = 0;
      mag = ONE_Q30;
      sum = longint'(ONE_Q30);
      while (r >= LN2_Q30 && k < 60) begin
         r = r - LN2_Q30;
         k++;
      end
      for (int n = 1; n <= 16; n++) begin
         mag = ((mag * r) >> 30) / 64'(n);
         if (n % 2 == 1) sum = sum - longint'(mag);
         else sum = sum + longint'(mag);
      end
      if (sum < 0) sum = 0;
      v = $unsigned(sum) >> k;
      q = (v + 64'd8192) >> 14;
      if (q > 64'd65535) q = 64'd65535;
      return q[HEAT_W-1:0];
   endfunction

   function automatic void wipe_store();
      foreach (heat_store[i]) heat_store[i] = '0;
   endfunction

   function automatic void splat_keypoint(longint cx, longint cy, longint ch);
      longint rad;
      longint spread;
      longint w;
      longint h;
      longint xtl;
      longint ytl;
      longint xbr;
      longint ybr;
      longint r2;
      longint dx;
      longint dy;
      longint d;
      longint e;
      longint idx;
      longint a;
      longint th;
      th     = longint'(TH_Q16);
      rad    = (radius == 0) ? 1 : longint'(radius);
      spread = (rad * longint'(SQRT_2TH_Q16)) >>> 18;
      w      = (map_w > PLANE_W) ? PLANE_W : longint'(map_w);
      h      = (map_h > PLANE_H) ? PLANE_H : longint'(map_h);
      xtl    = (cx < spread) ? 0 : (cx - spread) / 64;
      ytl    = (cy < spread) ? 0 : (cy - spread) / 64;
      xbr    = (cx + spread) / 64 + 1;
      ybr    = (cy + spread) / 64 + 1;
      if (xbr > w) xbr = w;
      if (ybr > h) ybr = h;
      r2 = rad * rad;
      for (longint x = xtl; x < xbr; x++) begin
         for (longint y = ytl; y < ybr; y++) begin
            dx = x * 64 - cx;
            dy = y * 64 - cy;
            d  = dx * dx + dy * dy;
            e  = (d << 19) / r2;
            if (e > th) continue;
            idx = (e * (LUT_N - 1) + th / 2) / th;
            if (idx >= LUT_N) idx = LUT_N - 1;
            a = (ch * PLANE_H + y) * PLANE_W + x;
            if (heat_store[a] < exp_table[idx]) heat_store[a] = exp_table[idx];
         end
      end
   endfunction

   initial begin
      errors = 0;
      for (int i = 0; i < LUT_N; i++)
         exp_table[i] = decay_q16((64'(i) * TH_Q16) / 64'(LUT_N - 1));
      wipe_store();
   end

   always @(posedge clock) begin
      int cx;
      int cy;
      logic [HEAT_W-1:0] want;
      if (reset) begin
         radius = RESET_RADIUS;
         map_w  = RESET_WIDTH;
         map_h  = RESET_HEIGHT;
         heat_due.delete();
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               CSR_SPREAD_RADIUS: radius = csr_wdata[RAD_W-1:0];
               CSR_MAP_WIDTH:     map_w  = csr_wdata[COORD_W-1:0];
               CSR_MAP_HEIGHT:    map_h  = csr_wdata[COORD_W-1:0];
               default: ;
            endcase
         end
         // results come from earlier requests, so check them first
         if (rsp.valid && rsp.ready) begin
            if (heat_due.size() == 0) begin
               $display("%0t: unexpected heat_value %0d", $time, rsp.heat_value);
               errors++;
            end else begin
               want = heat_due.pop_front();
               if (rsp.heat_value !== want) begin
                  $display("%0t: heat_value expected %0d actual %0d",
                           $time, want, rsp.heat_value);
                  errors++;
               end
            end
         end
         if (req.valid && req.ready) begin
            case (req.opcode)
               OP_DRAW: begin
                  cx = req.x_pos;
                  cy = req.y_pos;
                  if (cx >= 0 && cy >= 0 && req.channel < PLANES)
                     splat_keypoint(cx, cy, req.channel);
               end
               OP_READ: begin
                  if (req.channel < PLANES && req.pixel_col < PLANE_W
                      && req.pixel_row < PLANE_H)
                     heat_due.push_back(heat_store[(int'(req.channel) * PLANE_H
                        + int'(req.pixel_row)) * PLANE_W + int'(req.pixel_col)]);
                  else
                     heat_due.push_back('0);
               end
               OP_CLEAR: wipe_store();
               default: ;
            endcase
         end
      end
   end

endmodule

// ===== tb/gaussian_heatmap_render_unit_test.sv =====
module gaussian_heatmap_render_unit_test;
   import ghr_pkg::*;

   localparam int QUIET_DRAW  = 13000;
   localparam int QUIET_CLEAR = 140000;
   localparam int CYCLE_LIMIT = 3000000;

   logic                  clock;
   logic                  reset;
   logic                  csr_wr_en;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;
   int                    errors;
   int                    pending;
   int                    cycles;
   bit                    calm;
   int                    hold_asks;
   int                    last_x;
   int                    last_y;
   int                    last_ch;
   int                    cur_w;
   int                    cur_h;

   ghr_req_if req_ch();
   ghr_rsp_if rsp_ch();

   gaussian_heatmap_render_unit dut (
      .clock(clock), .reset(reset), .req_bus(req_ch), .rsp_bus(rsp_ch),
      .csr_wr_en(csr_wr_en), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   ghr_heat_monitor monitor (
      .clock(clock), .reset(reset), .req(req_ch), .rsp(rsp_ch),
      .csr_wr_en(csr_wr_en), .csr_index(csr_index), .csr_wdata(csr_wdata),
      .errors(errors), .pending(pending)
   );

   initial clock = 1'b0;
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("gaussian_heatmap_render_unit_test NOT OK");
         $finish;
      end
   end

   // response side: random back-pressure plus one long hold on request
   initial begin
      int served;
      served = 0;
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_asks > served) begin
            served++;
            rsp_ch.ready <= 1'b0;
            repeat (400) @(posedge clock);
         end else if (!calm && $urandom_range(0, 7) == 0) begin
            rsp_ch.ready <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clock);
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   task automatic send(opcode_type op, int x, int y, int ch, int col, int row);
      req_ch.valid     <= 1'b1;
      req_ch.opcode    <= op;
      req_ch.x_pos     <= x[POS_W-1:0];
      req_ch.y_pos     <= y[POS_W-1:0];
      req_ch.channel   <= ch[CH_W-1:0];
      req_ch.pixel_col <= col[PIX_W-1:0];
      req_ch.pixel_row <= row[PIX_W-1:0];
      do @(posedge clock); while (!req_ch.ready);
      if (!calm && $urandom_range(0, 5) == 0) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 14)) @(posedge clock);
      end
   endtask

   task automatic send_raw(logic [OPC_W-1:0] op);
      req_ch.valid  <= 1'b1;
      req_ch.opcode <= op;
      do @(posedge clock); while (!req_ch.ready);
   endtask

   task automatic settle(int quiet);
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (quiet) @(posedge clock);
   endtask

   task automatic set_reg(csr_index_type idx, int val);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val[CSR_DATA_W-1:0];
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic set_map(int rad, int w, int h);
      set_reg(CSR_SPREAD_RADIUS, rad);
      set_reg(CSR_MAP_WIDTH, w);
      set_reg(CSR_MAP_HEIGHT, h);
      cur_w = (w < 1) ? 1 : (w > 64 ? 64 : w);
      cur_h = (h < 1) ? 1 : (h > 64 ? 64 : h);
   endtask

   task automatic random_item();
      int pick;
      int ch;
      pick = $urandom_range(0, 99);
      ch = ($urandom_range(0, 9) < 6) ? $urandom_range(0, 3) : $urandom_range(0, 31);
      if (pick < 40) begin
         if ($urandom_range(0, 9) == 0) begin
            last_x = $signed(13'($urandom));
            last_y = $signed(13'($urandom));
         end else begin
            last_x = $urandom_range(0, cur_w * 64 - 1);
            last_y = $urandom_range(0, cur_h * 64 - 1);
         end
         last_ch = ch;
         send(OP_DRAW, last_x, last_y, ch, $urandom, $urandom);
      end else if (pick < 95) begin
         if (pick < 80 && last_x >= 0 && last_y >= 0)
            send(OP_READ, $urandom, $urandom, last_ch,
                 (last_x >>> 6) + $urandom_range(0, 6) - 3,
                 (last_y >>> 6) + $urandom_range(0, 6) - 3);
         else
            send(OP_READ, $urandom, $urandom, ch, $urandom, $urandom);
      end else begin
         send_raw(2'd3);
      end
   endtask

   initial begin
      int rad;
      cycles    = 0;
      calm      = 1'b0;
      hold_asks = 0;
      last_x    = 0;
      last_y    = 0;
      last_ch   = 0;
      cur_w     = 64;
      cur_h     = 64;
      reset     <= 1'b1;
      csr_wr_en <= 1'b0;
      csr_index <= CSR_SPREAD_RADIUS;
      csr_wdata <= '0;
      req_ch.valid     <= 1'b0;
      req_ch.opcode    <= OP_DRAW;
      req_ch.x_pos     <= '0;
      req_ch.y_pos     <= '0;
      req_ch.channel   <= '0;
      req_ch.pixel_col <= '0;
      req_ch.pixel_row <= '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: reset map, corners, absent keypoints, unused opcode, clear
      send(OP_READ, 0, 0, 0, 0, 0);
      send(OP_DRAW, 0, 0, 0, 0, 0);
      send(OP_DRAW, 4095, 4095, 31, 63, 63);
      send(OP_DRAW, -4096, 100, 1, 0, 0);
      send(OP_DRAW, 100, -1, 1, 0, 0);
      send(OP_READ, 0, 0, 0, 0, 0);
      send(OP_READ, 0, 0, 0, 1, 1);
      send(OP_READ, 0, 0, 31, 63, 63);
      send(OP_READ, 0, 0, 31, 40, 50);
      send(OP_READ, 0, 0, 1, 1, 1);
      send_raw(2'd3);
      send(OP_CLEAR, 0, 0, 0, 0, 0);
      send(OP_READ, 0, 0, 0, 0, 0);
      settle(QUIET_CLEAR);

      // zero radius on a one-pixel map
      set_map(0, 1, 1);
      send(OP_DRAW, 0, 0, 5, 0, 0);
      send(OP_DRAW, 2, 1, 6, 0, 0);
      send(OP_READ, 0, 0, 5, 0, 0);
      send(OP_READ, 0, 0, 6, 0, 0);
      send(OP_READ, 0, 0, 5, 1, 0);
      settle(QUIET_DRAW);

      // largest radius, oversize width, empty height
      set_map(16383, 127, 0);
      send(OP_DRAW, 2000, 2000, 7, 0, 0);
      send(OP_READ, 0, 0, 7, 31, 0);
      settle(QUIET_DRAW);
      set_map(8192, 127, 64);
      send(OP_DRAW, 2000, 2000, 7, 0, 0);
      send(OP_READ, 0, 0, 7, 31, 31);
      send(OP_READ, 0, 0, 7, 0, 63);
      settle(QUIET_DRAW);

      // random phases under varied map settings
      for (int ph = 0; ph < 7; ph++) begin
         rad = (ph == 3) ? 8192 : $urandom_range(64, 512);
         set_map(rad, (ph == 0) ? 64 : $urandom_range(1, 64),
                 (ph == 0) ? 64 : $urandom_range(1, 64));
         calm = (ph == 6);
         for (int i = 0; i < ((ph == 3) ? 15 : 55); i++) begin
            if (ph == 1 && i == 20) begin
               // stall the response side while reads keep coming
               hold_asks = hold_asks + 1;
               repeat (25) send(OP_READ, 0, 0, $urandom_range(0, 31), $urandom, $urandom);
            end
            if (ph == 2 && i == 30) settle(0);
            if (ph == 4 && i == 30) begin
               send(OP_CLEAR, 0, 0, 0, 0, 0);
               settle(QUIET_CLEAR);
            end
            random_item();
         end
         settle(QUIET_DRAW);
      end

      req_ch.valid <= 1'b0;
      while (pending != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      if (errors == 0) $display("gaussian_heatmap_render_unit_test OK");
      else $display("gaussian_heatmap_render_unit_test NOT OK");
      $finish;
   end

endmodule
